>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL module of the itemset support-count table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define AST_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("itemset table assertion failed");

// A condition that must never hold outside reset.
`define AST_NEVER(label, cond) \
  `AST_CLK(label, !(cond))

`endif

>>> src/isct_pkg.sv
// Package with the constants, codes, token type and key compare of the itemset table.
`default_nettype none

package isct_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int MAX_ITEMS   = 4;
  localparam int ITEM_BITS   = 16;
  localparam int KEY_W       = MAX_ITEMS * ITEM_BITS;
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int SIZE_W      = 3;
  localparam int COUNT_W     = 32;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INCREMENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SKIPPED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One operation as it travels down the row of cells.
  typedef struct packed {
    logic                valid;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key;
    logic [COUNT_W-1:0]  count;      // initial count, then the matched count
    logic                found;
    logic                inserted;
    logic                resolved;   // matched or placed; later cells leave it alone
    logic [FILL_W-1:0]   remaining;  // occupied cells still ahead, zero at the first free cell
  } token_t;

  // Compares the first size identifiers of two keys.
  function automatic logic key_match(input logic [KEY_W-1:0] a,
                                     input logic [KEY_W-1:0] b,
                                     input logic [SIZE_W-1:0] size);
    logic eq;
    eq = 1'b1;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if ((SIZE_W'(i) < size) &&
          (a[i*ITEM_BITS +: ITEM_BITS] != b[i*ITEM_BITS +: ITEM_BITS])) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

endpackage

`default_nettype wire

>>> src/isct_cell.sv
// One table cell: holds a single entry and passes the operation token to its neighbor.
`default_nettype none

module isct_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [isct_pkg::SIZE_W-1:0]   size,
  input  wire isct_pkg::token_t              tok_in,
  output isct_pkg::token_t                   tok_out
);
  import isct_pkg::*;

  logic [KEY_W-1:0]   key;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  token_t             tok;
  token_t             tok_next;
  logic               occupied;
  logic               hit;
  logic               place;

  assign occupied = (tok_in.remaining != '0);
  assign hit      = tok_in.valid && !tok_in.resolved && occupied &&
                    key_match(key, tok_in.key, size);
  assign place    = tok_in.valid && !tok_in.resolved && !occupied &&
                    (tok_in.kind == KIND_INSERT);

  always_comb begin
    count_next = count;
    if (hit && (tok_in.kind == KIND_INCREMENT) && (count != COUNT_MAX)) begin
      count_next = count + COUNT_W'(1);
    end
    tok_next           = tok_in;
    tok_next.remaining = occupied ? tok_in.remaining - FILL_W'(1) : '0;
    if (hit) begin
      tok_next.found    = 1'b1;
      tok_next.resolved = 1'b1;
      tok_next.count    = count_next;
    end
    if (place) begin
      tok_next.inserted = 1'b1;
      tok_next.resolved = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (place) begin
      key   <= tok_in.key;
      count <= tok_in.count;
    end else if (hit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

  assign tok_out = tok;

endmodule

`default_nettype wire

>>> src/isct_chain.sv
// The row of table cells, one per entry, linked head to tail.
`default_nettype none

module isct_chain (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [isct_pkg::SIZE_W-1:0]   size,
  input  wire isct_pkg::token_t              tok_in,
  output isct_pkg::token_t                   tok_out
);
  import isct_pkg::*;

  token_t link [0:TABLE_DEPTH];

  assign link[0] = tok_in;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    isct_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .size    (size),
      .tok_in  (link[g]),
      .tok_out (link[g+1])
    );
  end

  assign tok_out = link[TABLE_DEPTH];

endmodule

`default_nettype wire

>>> src/itemset_support_count_table_top.sv
// Top level of the itemset support-count table: command port, size register and result.
`default_nettype none
`include "assert_macros.svh"

// Usage. A command transaction is taken at a rising edge where start is high and busy is low;
// it carries kind, the four item identifiers and initial_count. The table is a row of
// TABLE_DEPTH cells, one per entry, and the command travels down it one cell per cycle:
// each occupied cell compares its key, the first match updates or reports its count, and an
// insert with no match is written into the first free cell it reaches.
// Timing: the result is shown once the command has passed through every cell of the row
// and the output register. Only one command is in flight, so busy stays high until the
// result is shown, and a new command can be taken at the edge that ends the done cycle.
// Results: found, support, status and entries_used are valid for the single cycle in which
// done is high. The receiver cannot stall, so it must take the result in that cycle.
// Configuration: itemset_size is written by a transaction on cfg_valid / cfg_ready with the
// value on cfg_data; cfg_ready is high only while no command is in flight or offered on
// start. A size of zero is used as one and a size above four as four.
// Reset: rst (synchronous, active high) empties the table, sets the size to one and drops
// busy and done. Stored keys and counts are not cleared; only entries below the fill level
// are ever compared, so no clearing pass is needed.

module itemset_support_count_table_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [isct_pkg::KIND_W-1:0]     kind,
  input  wire logic [15:0]                     item_a,
  input  wire logic [15:0]                     item_b,
  input  wire logic [15:0]                     item_c,
  input  wire logic [15:0]                     item_d,
  input  wire logic [isct_pkg::COUNT_W-1:0]    initial_count,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [isct_pkg::SIZE_W-1:0]     cfg_data,
  output logic                                 done,
  output logic                                 found,
  output logic [isct_pkg::COUNT_W-1:0]         support,
  output logic [isct_pkg::STATUS_W-1:0]        status,
  output logic [isct_pkg::FILL_W-1:0]          entries_used
);
  import isct_pkg::*;

  logic [SIZE_W-1:0]   itemset_size;
  logic [SIZE_W-1:0]   size_eff;
  logic [FILL_W-1:0]   fill_level;
  logic                accept;
  token_t              tok_head;
  token_t              tok_tail;
  logic [COUNT_W-1:0]  support_next;
  logic [STATUS_W-1:0] status_next;

  assign accept    = start && !busy;
  // Every cell must see the same size for the whole walk of a command, so the size
  // register never changes at the edge that takes a command.
  assign cfg_ready = !busy && !start;

  // Clamp the size register to the legal range of compared positions.
  always_comb begin
    size_eff = itemset_size;
    if (itemset_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (itemset_size > SIZE_W'(MAX_ITEMS)) begin
      size_eff = SIZE_W'(MAX_ITEMS);
    end
  end

  // The command enters the first cell in the cycle it is accepted.
  always_comb begin
    tok_head           = '0;
    tok_head.valid     = accept;
    tok_head.kind      = kind;
    tok_head.key       = {item_d[ITEM_BITS-1:0], item_c[ITEM_BITS-1:0],
                          item_b[ITEM_BITS-1:0], item_a[ITEM_BITS-1:0]};
    tok_head.count     = initial_count;
    tok_head.remaining = fill_level;
  end

  isct_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .size    (size_eff),
    .tok_in  (tok_head),
    .tok_out (tok_tail)
  );

  // Turn the token leaving the last cell into the result fields.
  always_comb begin
    support_next = '0;
    status_next  = ST_NOT_FOUND;
    if (tok_tail.found) begin
      support_next = tok_tail.count;
      status_next  = (tok_tail.kind == KIND_INSERT) ? ST_SKIPPED : ST_DONE;
    end else if (tok_tail.kind == KIND_INSERT) begin
      if (tok_tail.inserted) begin
        support_next = tok_tail.count;
        status_next  = ST_DONE;
      end else begin
        status_next  = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      done         <= 1'b0;
      fill_level   <= '0;
      itemset_size <= SIZE_W'(1);
    end else begin
      done <= tok_tail.valid;
      if (accept) begin
        busy <= 1'b1;
      end else if (tok_tail.valid) begin
        busy <= 1'b0;
      end
      if (tok_tail.valid && tok_tail.inserted) begin
        fill_level <= fill_level + FILL_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        itemset_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_tail.valid) begin
      found   <= tok_tail.found;
      support <= support_next;
      status  <= status_next;
    end
  end

  assign entries_used = fill_level;

  // The result strobe comes exactly when the command finishes.
  `AST_CLK(a_done_ends_busy, $fell(busy) |-> done)
  // The fill level never passes the number of cells.
  `AST_NEVER(a_fill_bound, fill_level > FILL_W'(TABLE_DEPTH))
  // A full report only happens with every cell occupied.
  `AST_CLK(a_full_means_full, (done && (status == ST_FULL)) |->
           (entries_used == FILL_W'(TABLE_DEPTH)))
  // The fill level grows by at most one per command and only with a result.
  `AST_CLK(a_fill_step, (fill_level != $past(fill_level)) |->
           (done && (fill_level == $past(fill_level) + FILL_W'(1))))

endmodule

`default_nettype wire
